>>> rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the periodic task dispatcher: request codes,
// slot states, payload structs and the command broadcast to the slot cells.
// ----------------------------------------------------------------------------
package ptd_pkg;

	// number of task slots, one cell each
	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	// request codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_CREATE  = 3'd1;
	localparam logic [2:0] REQ_SUSPEND = 3'd2;
	localparam logic [2:0] REQ_RESUME  = 3'd3;
	localparam logic [2:0] REQ_DELETE  = 3'd4;

	// configuration register address
	localparam logic [1:0] ADDR_TICK_DIVIDER = 2'd0;

	// slot states
	typedef enum logic [1:0] {
		ST_DORMANT   = 2'd0,
		ST_READY     = 2'd1,
		ST_SUSPENDED = 2'd2
	} slot_state_t;

	// command broadcast to the cells
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CREATE,
		CMD_SUSPEND,
		CMD_RESUME,
		CMD_DELETE
	} cmd_op_t;

	// controller states
	typedef enum logic {
		CTL_IDLE,
		CTL_PASS
	} ctl_state_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  slot;
		logic        has_routine;
		logic [15:0] period;
		logic [15:0] initial_delay;
	} req_t;

	typedef struct packed {
		logic [2:0] fired_slot;
		logic       fired;
		logic       accepted;
		logic       last;
	} rsp_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       period;
		logic [15:0]       delay;
	} cmd_t;

	// per-cell status seen by the controller
	typedef struct packed {
		logic tok;
		logic fire;
		logic tail;
	} cell_stat_t;

endpackage

>>> rtl/core/periodic_task_dispatcher_top.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_top
// Task slot table with a tick prescaler and a token-driven scheduling pass.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on req/req_valid/req_ready, results leave on
// rsp/rsp_valid/rsp_ready; a transfer happens when valid and ready are high.
// Commands (create, suspend, resume, delete) and ticks that do not end the
// prescaler give one result, registered at the transfer; a new request is
// taken in the cycle after when the result register is free.
// A tick that ends the prescaler starts a scheduling pass: a token walks the
// row of slot cells, one cell per cycle while the output register is free.
// Each fired slot gives one result, lowest slot first; a pass with no
// firing gives one result at its end.
// While a result waits in the output register the token holds in place.
// The tick_divider register sits at APB byte address 0; writing it also
// loads the prescaler. Reset empties all slots and sets the divider and
// prescaler to one; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ptd_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ptd_pkg::rsp_t  rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int N = ptd_pkg::TASK_SLOTS;

	ptd_pkg::ctl_state_t       state_q;
	ptd_pkg::ctl_state_t       state_d;
	logic [7:0]                tick_div_q;
	logic [7:0]                prescale_q;
	logic [7:0]                prescale_dec;
	logic [ptd_pkg::SLOT_W-1:0] cnt_q;
	logic                      fired_any_q;
	logic                      rsp_valid_q;
	ptd_pkg::rsp_t             rsp_q;
	ptd_pkg::rsp_t             rsp_d;
	logic                      rsp_load;
	logic                      out_free;
	logic                      req_xfer;
	logic                      cfg_wr;
	logic                      is_tick;
	logic                      start;
	logic                      adv;
	logic                      in_range;
	logic                      pass_fire;
	logic                      pass_tail;
	logic                      cnt_end;
	ptd_pkg::cmd_t             cmd;
	ptd_pkg::cell_stat_t       stat [N];
	logic [N-1:0]              fire_vec;
	logic [N-1:0]              tail_vec;
	logic [N-1:0]              tok_chain;
	logic [N:0]                any_chain;

	// config port
	assign pready = 1'b1;
	assign prdata = {24'd0, tick_div_q};
	assign cfg_wr = psel && penable && pwrite && (paddr == ptd_pkg::ADDR_TICK_DIVIDER);

	// handshakes
	assign out_free  = ~rsp_valid_q | rsp_ready;
	assign req_ready = (state_q == ptd_pkg::CTL_IDLE) && out_free;
	assign req_xfer  = req_valid & req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_tick      = (req.req_type == ptd_pkg::REQ_TICK);
	assign prescale_dec = prescale_q - 8'd1;
	assign start        = req_xfer && is_tick && (prescale_dec == 8'd0);
	assign adv          = (state_q == ptd_pkg::CTL_PASS) && out_free;
	assign in_range     = ({1'b0, req.slot} < 9'(N));
	assign cnt_end      = (cnt_q == ptd_pkg::SLOT_W'(N - 1));

	// command broadcast, only on a request transfer
	always_comb begin
		cmd.op     = ptd_pkg::CMD_NONE;
		cmd.slot   = req.slot[ptd_pkg::SLOT_W-1:0];
		cmd.period = req.period;
		cmd.delay  = req.initial_delay;
		if (req_xfer && in_range) begin
			case (req.req_type)
				ptd_pkg::REQ_CREATE:  cmd.op = req.has_routine ? ptd_pkg::CMD_CREATE
				                                               : ptd_pkg::CMD_NONE;
				ptd_pkg::REQ_SUSPEND: cmd.op = ptd_pkg::CMD_SUSPEND;
				ptd_pkg::REQ_RESUME:  cmd.op = ptd_pkg::CMD_RESUME;
				ptd_pkg::REQ_DELETE:  cmd.op = ptd_pkg::CMD_DELETE;
				default:              cmd.op = ptd_pkg::CMD_NONE;
			endcase
		end
	end

	// row of slot cells with token and pending-fire chains
	assign any_chain[N] = 1'b0;
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			ptd_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (ptd_pkg::SLOT_W'(g)),
				.cmd     (cmd),
				.start   (start),
				.adv     (adv),
				.tok_in  ((g == 0) ? start : tok_chain[(g == 0) ? 0 : g - 1]),
				.any_in  (any_chain[g + 1]),
				.any_out (any_chain[g]),
				.stat    (stat[g])
			);
			assign tok_chain[g] = stat[g].tok;
			assign fire_vec[g]  = stat[g].fire;
			assign tail_vec[g]  = stat[g].tail;
		end
	endgenerate

	assign pass_fire = |fire_vec;
	assign pass_tail = |tail_vec;

	// next state and result selection
	always_comb begin
		state_d  = state_q;
		rsp_load = 1'b0;
		rsp_d    = '0;
		case (state_q)
			ptd_pkg::CTL_IDLE: begin
				if (req_xfer) begin
					rsp_load       = ~start;
					rsp_d.accepted = is_tick || (cmd.op != ptd_pkg::CMD_NONE);
					rsp_d.last     = 1'b1;
					if (start) begin
						state_d = ptd_pkg::CTL_PASS;
					end
				end
			end
			ptd_pkg::CTL_PASS: begin
				if (adv) begin
					if (pass_fire) begin
						rsp_load         = 1'b1;
						rsp_d.fired_slot = 3'(cnt_q);
						rsp_d.fired      = 1'b1;
						rsp_d.accepted   = 1'b1;
						rsp_d.last       = pass_tail;
					end else if (cnt_end && !fired_any_q) begin
						rsp_load       = 1'b1;
						rsp_d.accepted = 1'b1;
						rsp_d.last     = 1'b1;
					end
					if (cnt_end) begin
						state_d = ptd_pkg::CTL_IDLE;
					end
				end
			end
			default: begin
				state_d = ptd_pkg::CTL_IDLE;
			end
		endcase
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptd_pkg::CTL_IDLE;
			cnt_q       <= '0;
			fired_any_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q       <= '0;
				fired_any_q <= 1'b0;
			end else if (adv) begin
				cnt_q       <= cnt_q + ptd_pkg::SLOT_W'(1);
				fired_any_q <= fired_any_q | pass_fire;
			end
		end
	end

	// divider and prescaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_div_q <= 8'd1;
			prescale_q <= 8'd1;
		end else if (cfg_wr) begin
			tick_div_q <= pwdata[7:0];
			prescale_q <= pwdata[7:0];
		end else if (req_xfer && is_tick) begin
			prescale_q <= start ? tick_div_q : prescale_dec;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> rtl/core/ptd_cell.sv
// ----------------------------------------------------------------------------
// ptd_cell
// One task slot: present flag, state, period and delay. Applies commands
// addressed to it and, while it holds the pass token, advances its delay.
// ----------------------------------------------------------------------------
module ptd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ptd_pkg::SLOT_W-1:0] idx,
	input  ptd_pkg::cmd_t              cmd,
	input  logic                       start,
	input  logic                       adv,
	input  logic                       tok_in,
	input  logic                       any_in,
	output logic                       any_out,
	output ptd_pkg::cell_stat_t        stat
);

	logic                 present_q;
	ptd_pkg::slot_state_t state_q;
	logic [15:0]          period_q;
	logic [15:0]          delay_q;
	logic                 tok_q;
	logic                 sel;
	logic                 fire_cond;
	logic                 step;

	// due to fire on the pass
	assign fire_cond = present_q && (state_q == ptd_pkg::ST_READY) && (delay_q == 16'd0);
	assign any_out   = fire_cond | any_in;
	assign sel       = (cmd.slot == idx);
	assign step      = tok_q & adv;

	assign stat.tok  = tok_q;
	assign stat.fire = tok_q & fire_cond;
	assign stat.tail = tok_q & ~any_in;

	// token hands on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (start || adv) begin
			tok_q <= tok_in;
		end
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			state_q   <= ptd_pkg::ST_DORMANT;
			period_q  <= 16'd0;
			delay_q   <= 16'd0;
		end else if (step) begin
			delay_q <= fire_cond ? (period_q - 16'd1) : (delay_q - 16'd1);
		end else if (sel) begin
			case (cmd.op)
				ptd_pkg::CMD_CREATE: begin
					present_q <= 1'b1;
					state_q   <= ptd_pkg::ST_READY;
					period_q  <= cmd.period;
					delay_q   <= cmd.delay;
				end
				ptd_pkg::CMD_SUSPEND: begin
					state_q <= ptd_pkg::ST_SUSPENDED;
				end
				ptd_pkg::CMD_RESUME: begin
					state_q <= ptd_pkg::ST_READY;
					delay_q <= 16'd0;
				end
				ptd_pkg::CMD_DELETE: begin
					present_q <= 1'b0;
					state_q   <= ptd_pkg::ST_DORMANT;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
